// ===== hdl/jhs_pkg.sv =====
// Package for the joint homing sequencer: shared types, opcodes, register indices and move selectors.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jhs_pkg;
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_TABLE   = 2'd2;

    localparam logic [1:0] REG_WAIT  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_TPS   = 2'd2;

    // Move selectors carried in the command.
    localparam logic [1:0] MV_OUT   = 2'd0;
    localparam logic [1:0] MV_CROSS = 2'd1;
    localparam logic [1:0] MV_BACK  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture sensor edges for the joints in use
        logic offsets;   // compute offsets for the joints in use
        logic vel_start; // start the velocity divider
        logic [1:0] move; // 0 first, 1 middle, 2 last move
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic vel_busy;
    } t_stat;
endpackage
`default_nettype wire

// ===== hdl/joint_homing_sequencer_top.sv =====
// Top level of the joint homing sequencer: registers, controller and datapath.
// Depends on jhs_pkg, jhs_ctrl, jhs_datapath and jhs_velocity.
`timescale 1ns / 1ps
`default_nettype none
// Joint homing sequencer. Feed one sample word per joint for each control tick;
// the word with tlast set runs the step, after which one result word per joint
// in use is sent. A step sums the phase lengths of the joints in use and then
// evaluates; when a joint is moving, the velocity unit runs next (setup states
// M1 to M3, the partial-product sums, a restoring divider over the 103
// numerator bits and a pick-up of the result). Result words then go out one per
// cycle while the receiver is ready, and the controller returns to idle; no
// input is taken until the last result of the step is out. Configuration writes
// are taken at any time and should be made only while no step is in flight.
module joint_homing_sequencer_top import jhs_pkg::*; #(
    parameter int MAX_JOINTS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata from bit 0: time_ticks[32], joint_index[4], measured_position[32],
    // sensor_level[1], range_high[32], range_low[32], phase_length[24], zeros
    input  wire logic [159:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,  // last_joint
    input  wire logic [1:0]   s_axis_tuser,  // operation
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata from bit 0: out_joint[4], velocity[32], home_offset[32], homing_done[1], zeros
    output logic [71:0]       m_axis_tdata,
    output logic              m_axis_tlast,  // last_result
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [23:0]  i_cfg_data
);
    logic [23:0] r_wait;
    logic [4:0]  r_count;
    logic [15:0] r_tps;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 24'd5000; r_count <= 5'd15; r_tps <= 16'd1000;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WAIT) r_wait <= i_cfg_data;
            else if (i_cfg_index == REG_COUNT) r_count <= i_cfg_data[4:0];
            else if (i_cfg_index == REG_TPS) r_tps <= i_cfg_data[15:0];
        end
    end

    logic w_fire, w_swe, w_twe, w_done;
    t_cmd w_cmd;
    t_stat w_stat;
    logic [$clog2(MAX_JOINTS):0] w_act;
    logic [25:0] w_el;
    logic signed [31:0] w_vel, w_off, w_ovel, w_ooff;
    logic [23:0] w_ph, w_rph;
    logic [3:0] w_rd, w_oj;

    assign w_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata = {3'd0, w_done, w_ooff, w_ovel, w_oj};

    jhs_ctrl #(.MAX_JOINTS(MAX_JOINTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire), .i_op(s_axis_tuser),
        .i_time(s_axis_tdata[31:0]), .i_joint(s_axis_tdata[35:32]),
        .i_last(s_axis_tlast), .i_wait(r_wait), .i_n(r_count),
        .o_in_ready(s_axis_tready), .o_sample_we(w_swe), .o_table_we(w_twe),
        .o_active(w_act), .o_elapsed(w_el), .o_cmd(w_cmd), .i_stat(w_stat),
        .i_vel(w_vel), .i_phase(w_ph), .i_rd_phase(w_rph), .o_rd_joint(w_rd),
        .i_offset(w_off), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_out_joint(w_oj), .o_out_vel(w_ovel), .o_out_off(w_ooff),
        .o_out_done(w_done), .o_out_last(m_axis_tlast)
    );

    jhs_datapath #(.MAX_JOINTS(MAX_JOINTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample_we(w_swe), .i_table_we(w_twe),
        .i_joint(s_axis_tdata[35:32]), .i_pos(s_axis_tdata[67:36]),
        .i_sensor(s_axis_tdata[68]), .i_high(s_axis_tdata[100:69]),
        .i_low(s_axis_tdata[132:101]), .i_phase(s_axis_tdata[156:133]),
        .i_n(r_count > 5'(MAX_JOINTS) ? 5'(MAX_JOINTS) : r_count), .i_tps(r_tps),
        .i_active(w_act), .i_elapsed(w_el), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_vel(w_vel), .o_phase_sel(w_ph), .o_rd_phase(w_rph),
        .i_rd_joint(w_rd), .o_offset(w_off)
    );
endmodule
`default_nettype wire

// ===== hdl/jhs_datapath.sv =====
// Datapath: per-joint tables, edge latches, offsets and the velocity unit.
// Depends on jhs_pkg and jhs_velocity.
`timescale 1ns / 1ps
`default_nettype none
module jhs_datapath import jhs_pkg::*; #(
    parameter int MAX_JOINTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_sample_we,
    input  wire logic        i_table_we,
    input  wire logic [3:0]  i_joint,
    input  wire logic signed [31:0] i_pos,
    input  wire logic        i_sensor,
    input  wire logic signed [31:0] i_high,
    input  wire logic signed [31:0] i_low,
    input  wire logic [23:0] i_phase,
    input  wire logic [4:0]  i_n,
    input  wire logic [15:0] i_tps,
    input  wire logic [$clog2(MAX_JOINTS):0] i_active,
    input  wire logic [25:0] i_elapsed,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic signed [31:0] o_vel,
    output logic [23:0]      o_phase_sel,
    output logic [23:0]      o_rd_phase,
    input  wire logic [3:0]  i_rd_joint,
    output logic signed [31:0] o_offset
);
    localparam int JW = $clog2(MAX_JOINTS) > 0 ? $clog2(MAX_JOINTS) : 1;

    logic [MAX_JOINTS-1:0] r_sn, r_sb, r_ss, r_es;
    logic signed [31:0] r_pos [MAX_JOINTS];
    logic signed [31:0] r_stp [MAX_JOINTS];
    logic signed [31:0] r_etp [MAX_JOINTS];
    logic signed [31:0] r_off [MAX_JOINTS];
    logic signed [31:0] r_hi [MAX_JOINTS];
    logic signed [31:0] r_lo [MAX_JOINTS];
    logic [23:0] r_ph [MAX_JOINTS];

    logic [JW-1:0] w_act;
    assign w_act = i_active[JW-1:0];
    logic w_act_ok;
    assign w_act_ok = i_active < MAX_JOINTS;
    assign o_phase_sel = w_act_ok ? r_ph[w_act] : 24'd0;

    // Phase length of the joint the controller is walking, for the total time.
    assign o_rd_phase = (int'(i_rd_joint) < MAX_JOINTS) ? r_ph[i_rd_joint[JW-1:0]] : 24'd0;

    assign o_offset = (int'(i_rd_joint) < MAX_JOINTS) ? r_off[i_rd_joint[JW-1:0]] : 32'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn <= '0; r_sb <= '0; r_ss <= '0; r_es <= '0;
            for (int i = 0; i < MAX_JOINTS; i++) begin
                r_pos[i] <= '0; r_stp[i] <= '0; r_etp[i] <= '0; r_off[i] <= '0;
            end
        end else begin
            if (i_sample_we && int'(i_joint) < MAX_JOINTS) begin
                r_pos[i_joint[JW-1:0]] <= i_pos;
                r_sb[i_joint[JW-1:0]]  <= r_sn[i_joint[JW-1:0]];
                r_sn[i_joint[JW-1:0]]  <= i_sensor;
            end
            for (int i = 0; i < MAX_JOINTS; i++) begin
                if (i < i_n) begin
                    if (i_cmd.latch && !r_sn[i] && r_sb[i]) begin
                        r_stp[i] <= r_pos[i]; r_ss[i] <= 1'b1;
                    end else if (i_cmd.latch && r_sn[i] && !r_sb[i]) begin
                        r_etp[i] <= r_pos[i]; r_es[i] <= 1'b1;
                    end
                    if (i_cmd.offsets) begin
                        logic signed [32:0] s;
                        s = 33'(r_stp[i]) + 33'(r_etp[i]);
                        r_off[i] <= (r_ss[i] && r_es[i]) ? s[32:1] : 32'sd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_table_we && int'(i_joint) < MAX_JOINTS) begin
            r_hi[i_joint[JW-1:0]] <= i_high;
            r_lo[i_joint[JW-1:0]] <= i_low;
            r_ph[i_joint[JW-1:0]] <= i_phase;
        end
    end

    // Move distance and length for the selected move; the distance is saturated to 32 bits.
    logic signed [31:0] w_h, w_l, w_d;
    logic signed [32:0] w_dd;
    logic [25:0] w_len;
    assign w_h = w_act_ok ? r_hi[w_act] : 32'sd0;
    assign w_l = w_act_ok ? r_lo[w_act] : 32'sd0;
    assign w_dd = 33'(w_l) - 33'(w_h);
    always_comb begin
        unique case (i_cmd.move)
            MV_OUT: begin w_d = w_h; w_len = {2'b00, o_phase_sel}; end
            MV_CROSS: begin
                w_len = {1'b0, o_phase_sel, 1'b0};
                if (w_dd > 33'sh07FFFFFFF) w_d = 32'sh7FFFFFFF;
                else if (w_dd < -33'sh080000000) w_d = 32'sh80000000;
                else w_d = w_dd[31:0];
            end
            default: begin
                w_len = {2'b00, o_phase_sel};
                w_d = (w_l == 32'sh80000000) ? 32'sh7FFFFFFF : -w_l;
            end
        endcase
    end

    jhs_velocity u_vel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.vel_start),
        .i_d(w_d), .i_e(i_elapsed), .i_len(w_len), .i_tps(i_tps),
        .o_busy(o_stat.vel_busy), .o_vel(o_vel)
    );
endmodule
`default_nettype wire

// ===== hdl/jhs_velocity.sv =====
// Multi-cycle velocity unit: 6*|d|*tps*e*(len-e) / len^2, one quotient bit a cycle.
// Depends on jhs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jhs_velocity import jhs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic signed [31:0] i_d,
    input  wire logic [25:0] i_e,
    input  wire logic [25:0] i_len,
    input  wire logic [15:0] i_tps,
    output logic             o_busy,
    output logic signed [31:0] o_vel
);
    localparam logic [2:0] S_IDLE = 3'd0, S_M1 = 3'd1, S_M2 = 3'd2, S_M3 = 3'd3,
                           S_MUL = 3'd4, S_DIV = 3'd5;
    logic [2:0] r_st, n_st;
    logic r_neg, r_big, r_zero;
    logic [31:0] r_mag;
    logic [25:0] r_e, r_len;
    logic [15:0] r_tps;
    logic [51:0] r_b, r_den;
    logic [50:0] r_a;
    logic [102:0] r_num;
    logic [52:0] r_rem;
    logic [31:0] r_q;
    logic [6:0] r_i;
    logic [1:0] r_pp;

    assign o_busy = r_st != S_IDLE;

    logic [52:0] w_trial;
    assign w_trial = {r_rem[51:0], r_num[102]};

    // The numerator is built from four 26 by 26 bit partial products, one a cycle.
    logic [25:0] w_aseg, w_bseg;
    logic [51:0] w_pp;
    logic [102:0] w_ppx;
    assign w_aseg = r_pp[1] ? {1'b0, r_a[50:26]} : r_a[25:0];
    assign w_bseg = r_pp[0] ? r_b[51:26] : r_b[25:0];
    assign w_pp = 52'(w_aseg) * 52'(w_bseg);
    always_comb begin
        unique case (r_pp)
            2'd0: w_ppx = {51'd0, w_pp};
            2'd3: w_ppx = {w_pp[50:0], 52'd0};
            default: w_ppx = {25'd0, w_pp, 26'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_start) n_st = S_M1;
            S_M1: n_st = S_M2;
            S_M2: n_st = S_M3;
            S_M3: n_st = r_zero ? S_IDLE : S_MUL;
            S_MUL: if (r_pp == 2'd3) n_st = S_DIV;
            S_DIV: if (r_i == 7'd0) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Divider walks 103 numerator bits; any quotient bit at 32 or above saturates.
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: if (i_start) begin
                r_neg <= i_d[31];
                r_mag <= i_d[31] ? 32'(-33'(i_d)) : 32'(i_d);
                r_e <= i_e; r_len <= i_len; r_tps <= i_tps;
                r_zero <= (i_len == 26'd0) || (i_e >= i_len);
                o_vel <= '0;
            end
            S_M1: begin
                r_a <= 51'(48'(r_mag) * 48'(r_tps)) * 51'd6;
                r_b <= 52'(r_e) * 52'(r_len - r_e);
            end
            S_M2: begin
                r_den <= 52'(r_len) * 52'(r_len);
            end
            S_M3: begin
                r_num <= '0; r_pp <= 2'd0;
                r_rem <= '0; r_q <= '0; r_big <= 1'b0; r_i <= 7'd102;
            end
            S_MUL: begin
                r_num <= r_num + w_ppx;
                r_pp <= r_pp + 2'd1;
            end
            S_DIV: begin
                logic big;
                logic [31:0] q;
                big = r_big; q = r_q;
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    if (r_i >= 7'd32) big = 1'b1;
                    else q[r_i[4:0]] = 1'b1;
                end else begin
                    r_rem <= w_trial;
                end
                r_num <= {r_num[101:0], 1'b0};
                r_big <= big; r_q <= q; r_i <= r_i - 7'd1;
                if (r_i == 7'd0) begin
                    if (r_neg) o_vel <= (big || q > 32'h80000000) ? 32'sh80000000 : -q;
                    else o_vel <= (big || q[31]) ? 32'sh7FFFFFFF : q;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/jhs_ctrl.sv =====
// Controller: input handshake, step sequencing and result emission.
// Depends on jhs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jhs_ctrl import jhs_pkg::*; #(
    parameter int MAX_JOINTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_fire,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_time,
    input  wire logic [3:0]  i_joint,
    input  wire logic        i_last,
    input  wire logic [23:0] i_wait,
    input  wire logic [4:0]  i_n,
    output logic             o_in_ready,
    output logic             o_sample_we,
    output logic             o_table_we,
    output logic [$clog2(MAX_JOINTS):0] o_active,
    output logic [25:0]      o_elapsed,
    output t_cmd             o_cmd,
    input  wire t_stat       i_stat,
    input  wire logic signed [31:0] i_vel,
    input  wire logic [23:0] i_phase,
    input  wire logic [23:0] i_rd_phase,
    output logic [3:0]       o_rd_joint,
    input  wire logic signed [31:0] i_offset,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_out_joint,
    output logic signed [31:0] o_out_vel,
    output logic signed [31:0] o_out_off,
    output logic             o_out_done,
    output logic             o_out_last
);
    localparam int AW = $clog2(MAX_JOINTS) + 1;
    localparam int TW = $clog2(MAX_JOINTS) + 26;
    localparam logic [2:0] S_IDLE = 3'd0, S_EVAL = 3'd1, S_WAITV = 3'd2,
                           S_EMIT = 3'd3, S_HOLD = 3'd4, S_SUM = 3'd5;
    logic [2:0] r_st;
    logic [AW-1:0] r_act;
    logic [31:0] r_base, r_start, r_t;
    logic r_known, r_done;
    logic [AW-1:0] r_who;
    logic [4:0] r_i;
    logic signed [31:0] r_v;
    logic [TW-1:0] r_tot;

    logic [4:0] w_n;
    assign w_n = (i_n > 5'(MAX_JOINTS)) ? 5'(MAX_JOINTS) : i_n;
    assign o_in_ready = r_st == S_IDLE;
    assign o_active = r_act;
    assign o_sample_we = i_in_fire && i_op == OP_SAMPLE && {1'b0, i_joint} < w_n;
    assign o_table_we = i_in_fire && i_op == OP_TABLE;
    assign o_rd_joint = r_i[3:0];

    // Window arithmetic in 34 bits so nothing wraps.
    logic [33:0] w_b, w_l, w_t;
    assign w_t = {2'b00, r_t};
    assign w_b = 34'(r_start) + 34'(r_base);
    assign w_l = {10'd0, i_phase};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_act <= '0; r_base <= '0; r_start <= '0;
            r_known <= 1'b0; r_done <= 1'b0; o_valid <= 1'b0; o_cmd <= '0;
        end else begin
            o_cmd.latch <= 1'b0; o_cmd.offsets <= 1'b0; o_cmd.vel_start <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_in_fire) begin
                    if (i_op == OP_RESTART) begin
                        r_act <= '0; r_base <= '0; r_done <= 1'b0;
                    end else if (i_op == OP_SAMPLE) begin
                        if (!r_known) begin
                            r_start <= i_time + 32'(i_wait); r_known <= 1'b1;
                        end
                        r_t <= i_time;
                        if (i_last) begin
                            r_st <= S_SUM; r_i <= '0; r_tot <= '0;
                        end
                    end
                end
                // Total time is summed one joint a cycle.
                S_SUM: begin
                    if (r_i < w_n) begin
                        r_tot <= r_tot + TW'({i_rd_phase, 2'b00});
                        r_i <= r_i + 5'd1;
                    end else begin
                        r_st <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_who <= AW'(MAX_JOINTS); r_v <= '0; r_st <= S_EMIT;
                    r_i <= '0;
                    if (!r_done && r_t >= r_start) begin
                        if ({2'b00, r_t} <= 34'(r_start) + 34'(r_tot)) begin
                            if (r_act < AW'(w_n)) begin
                                r_who <= r_act;
                                if (w_t >= w_b && w_t < w_b + w_l) begin
                                    o_cmd.move <= MV_OUT; o_cmd.vel_start <= 1'b1;
                                    o_elapsed <= 26'(w_t - w_b); r_st <= S_WAITV;
                                end else if (w_t >= w_b && w_t < w_b + 3 * w_l) begin
                                    o_cmd.move <= MV_CROSS; o_cmd.vel_start <= 1'b1;
                                    o_cmd.latch <= 1'b1;
                                    o_elapsed <= 26'(w_t - w_b - w_l); r_st <= S_WAITV;
                                end else if (w_t >= w_b && w_t < w_b + 4 * w_l) begin
                                    o_cmd.move <= MV_BACK; o_cmd.vel_start <= 1'b1;
                                    o_elapsed <= 26'(w_t - w_b - 3 * w_l); r_st <= S_WAITV;
                                end else if (w_t >= w_b) begin
                                    r_base <= r_base + {6'd0, i_phase, 2'b00};
                                    r_act <= r_act + 1'b1;
                                end
                            end
                        end else begin
                            o_cmd.offsets <= 1'b1; r_done <= 1'b1; r_st <= S_HOLD;
                        end
                    end
                end
                S_HOLD: r_st <= S_EMIT;
                S_WAITV: if (!o_cmd.vel_start && !i_stat.vel_busy) begin
                    r_v <= i_vel; r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (!o_valid || i_ready) begin
                        if (r_i < w_n) begin
                            o_valid <= 1'b1;
                            o_out_joint <= r_i[3:0];
                            o_out_vel <= ({1'b0, r_i} == 6'(r_who)) ? r_v : 32'sd0;
                            o_out_off <= i_offset;
                            o_out_done <= r_done;
                            o_out_last <= r_i + 5'd1 == w_n;
                            r_i <= r_i + 5'd1;
                        end else begin
                            o_valid <= 1'b0; r_st <= S_IDLE;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
